// ----- rtl/ost_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ost_pkg
// Types, codes and sizes shared by the ordered slot table modules.
// ----------------------------------------------------------------------------
package ost_pkg;

	localparam int CAPACITY     = 64;
	localparam int ELEMENT_BITS = 32;
	localparam int BYTES        = ELEMENT_BITS / 8;
	localparam int SLOT_W       = 6;
	localparam int CNT_W        = 7;
	localparam int IDX_W        = 8;
	localparam int NB_W         = 3;
	localparam int STEP_W       = 5;

	localparam logic [2:0] OP_PUSH         = 3'd0;
	localparam logic [2:0] OP_RESERVE      = 3'd1;
	localparam logic [2:0] OP_INSERT       = 3'd2;
	localparam logic [2:0] OP_REMOVE_AT    = 3'd3;
	localparam logic [2:0] OP_REMOVE_VALUE = 3'd4;
	localparam logic [2:0] OP_SWAP         = 3'd5;
	localparam logic [2:0] OP_GET          = 3'd6;
	localparam logic [2:0] OP_FIND         = 3'd7;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;

	// sequencer steps, shared by controller and datapath
	localparam logic [STEP_W-1:0] S_IDLE     = 5'd0;
	localparam logic [STEP_W-1:0] S_DECODE   = 5'd1;
	localparam logic [STEP_W-1:0] S_SCAN     = 5'd2;
	localparam logic [STEP_W-1:0] S_APPEND   = 5'd3;
	localparam logic [STEP_W-1:0] S_INS_RD   = 5'd4;
	localparam logic [STEP_W-1:0] S_INS_WR   = 5'd5;
	localparam logic [STEP_W-1:0] S_RM_RD    = 5'd6;
	localparam logic [STEP_W-1:0] S_RM_SLOT  = 5'd7;
	localparam logic [STEP_W-1:0] S_RM_RDI   = 5'd8;
	localparam logic [STEP_W-1:0] S_RM_WR    = 5'd9;
	localparam logic [STEP_W-1:0] S_GET_RD   = 5'd10;
	localparam logic [STEP_W-1:0] S_GET_ES   = 5'd11;
	localparam logic [STEP_W-1:0] S_GET_DATA = 5'd12;
	localparam logic [STEP_W-1:0] S_SW_A     = 5'd13;
	localparam logic [STEP_W-1:0] S_SW_B     = 5'd14;
	localparam logic [STEP_W-1:0] S_SW_WA    = 5'd15;
	localparam logic [STEP_W-1:0] S_SW_WB    = 5'd16;
	localparam logic [STEP_W-1:0] S_SR_OL    = 5'd17;
	localparam logic [STEP_W-1:0] S_SR_ES    = 5'd18;
	localparam logic [STEP_W-1:0] S_SR_CMP   = 5'd19;
	localparam logic [STEP_W-1:0] S_FIN      = 5'd20;

	typedef struct packed {
		logic [STEP_W-1:0] step;
		logic              take;
		logic              set_bad;
		logic              set_full;
		logic              out_load;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       full;
		logic       holes_nz;
		logic       pos_bad;
		logic       swap_bad;
		logic       nb_bad;
		logic       slot_free;
		logic       ins_done;
		logic       loop_end;
		logic       match;
	} sts_t;

endpackage

// ----- rtl/ordered_slot_table_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_slot_table_top
// 64-entry element store with an ordered list of slot numbers.
// ----------------------------------------------------------------------------
// One word is handled at a time; the order list has one read port and one
// write port. The next word can be accepted in the cycle after the one that
// loads the result of the last word into the output register. Push and
// reserve first scan for a free slot when holes exist; insert does the same
// and then shifts the entries above its position up one by one. Remove at a
// position shifts the entries above it down one by one. Find examines one
// entry after another, each by an order list read, an element read and a
// compare. Remove by value is such a search followed by a remove. A word
// refused for a full table or a bad position goes straight to the final
// step. The final step waits while a stalled result word holds the output
// register. A new word may be accepted while the previous result still
// waits at the output.
module ordered_slot_table_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [2:0]                          opcode,
	input  logic signed [ost_pkg::IDX_W-1:0]    index_a,
	input  logic [ost_pkg::SLOT_W-1:0]          index_b,
	input  logic [ost_pkg::ELEMENT_BITS-1:0]    element_value,
	input  logic [ost_pkg::NB_W-1:0]            compare_bytes,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          status,
	output logic [ost_pkg::SLOT_W-1:0]          position,
	output logic [ost_pkg::SLOT_W-1:0]          slot,
	output logic [ost_pkg::ELEMENT_BITS-1:0]    read_data,
	output logic [ost_pkg::CNT_W-1:0]           entry_count
);

	ost_pkg::cmd_t cmd;
	ost_pkg::sts_t sts;

	ost_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ost_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.opcode        (opcode),
		.index_a       (index_a),
		.index_b       (index_b),
		.element_value (element_value),
		.compare_bytes (compare_bytes),
		.status        (status),
		.position      (position),
		.slot          (slot),
		.read_data     (read_data),
		.entry_count   (entry_count)
	);

endmodule

// ----- rtl/ost_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ost_dp
// Datapath: order list and element memories, counters, occupancy map,
// loop index and result registers. Acts on the step given by the controller.
// ----------------------------------------------------------------------------
module ost_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ost_pkg::cmd_t                       cmd,
	output ost_pkg::sts_t                       sts,
	input  logic [2:0]                          opcode,
	input  logic signed [ost_pkg::IDX_W-1:0]    index_a,
	input  logic [ost_pkg::SLOT_W-1:0]          index_b,
	input  logic [ost_pkg::ELEMENT_BITS-1:0]    element_value,
	input  logic [ost_pkg::NB_W-1:0]            compare_bytes,
	output logic [1:0]                          status,
	output logic [ost_pkg::SLOT_W-1:0]          position,
	output logic [ost_pkg::SLOT_W-1:0]          slot,
	output logic [ost_pkg::ELEMENT_BITS-1:0]    read_data,
	output logic [ost_pkg::CNT_W-1:0]           entry_count
);

	logic [2:0]                        op_q;
	logic [ost_pkg::IDX_W-1:0]         ia_q;
	logic [ost_pkg::SLOT_W-1:0]        ib_q;
	logic [ost_pkg::ELEMENT_BITS-1:0]  val_q;
	logic [ost_pkg::NB_W-1:0]          nb_q;

	logic [ost_pkg::CNT_W-1:0]         count_q;
	logic [ost_pkg::CNT_W-1:0]         holes_q;
	logic [ost_pkg::CAPACITY-1:0]      used_q;
	logic [ost_pkg::CNT_W-1:0]         i_q;
	logic [ost_pkg::SLOT_W-1:0]        s_q;
	logic [ost_pkg::SLOT_W-1:0]        p_q;
	logic [ost_pkg::SLOT_W-1:0]        t_q;

	logic [ost_pkg::SLOT_W-1:0]        ol_mem [ost_pkg::CAPACITY];
	logic [ost_pkg::ELEMENT_BITS-1:0]  es_mem [ost_pkg::CAPACITY];
	logic [ost_pkg::SLOT_W-1:0]        ol_rd_q;
	logic [ost_pkg::ELEMENT_BITS-1:0]  es_rd_q;

	logic [1:0]                        res_status_q;
	logic [ost_pkg::SLOT_W-1:0]        res_pos_q;
	logic [ost_pkg::SLOT_W-1:0]        res_slot_q;
	logic [ost_pkg::ELEMENT_BITS-1:0]  res_data_q;

	logic [1:0]                        out_status_q;
	logic [ost_pkg::SLOT_W-1:0]        out_pos_q;
	logic [ost_pkg::SLOT_W-1:0]        out_slot_q;
	logic [ost_pkg::ELEMENT_BITS-1:0]  out_data_q;
	logic [ost_pkg::CNT_W-1:0]         out_count_q;

	logic [ost_pkg::CNT_W-1:0]         i_m1;
	logic [ost_pkg::SLOT_W-1:0]        ol_raddr;
	logic [ost_pkg::SLOT_W-1:0]        ol_waddr;
	logic [ost_pkg::SLOT_W-1:0]        ol_wdata;
	logic                              ol_we;
	logic [ost_pkg::ELEMENT_BITS-1:0]  cmp_mask;
	logic [ost_pkg::SLOT_W-1:0]        ins_pos;
	logic                              ia_neg;

	assign i_m1   = i_q - 1'b1;
	assign ia_neg = ia_q[ost_pkg::IDX_W-1];

	// insert position clamped to 0..count
	always_comb begin
		if (ia_neg)
			ins_pos = '0;
		else if (ia_q > {1'b0, count_q})
			ins_pos = count_q[ost_pkg::SLOT_W-1:0];
		else
			ins_pos = ia_q[ost_pkg::SLOT_W-1:0];
	end

	always_comb begin
		cmp_mask = '1;
		if (op_q == ost_pkg::OP_FIND) begin
			for (int k = 0; k < ost_pkg::BYTES; k++)
				cmp_mask[k*8 +: 8] = {8{k < int'(nb_q)}};
		end
	end

	always_comb begin
		sts.op        = op_q;
		sts.full      = (count_q == ost_pkg::CNT_W'(ost_pkg::CAPACITY));
		sts.holes_nz  = (holes_q != '0);
		sts.pos_bad   = ia_neg || (ia_q >= {1'b0, count_q});
		sts.swap_bad  = ia_neg || (ia_q >= {1'b0, count_q}) || ({1'b0, ib_q} >= count_q);
		sts.nb_bad    = (nb_q > ost_pkg::NB_W'(ost_pkg::BYTES));
		sts.slot_free = !used_q[i_q[ost_pkg::SLOT_W-1:0]];
		sts.ins_done  = (i_q == {1'b0, p_q});
		sts.loop_end  = (i_q >= count_q);
		sts.match     = (((es_rd_q ^ val_q) & cmp_mask) == '0);
	end

	// order list port selection
	always_comb begin
		ol_raddr = i_q[ost_pkg::SLOT_W-1:0];
		ol_waddr = p_q;
		ol_wdata = s_q;
		ol_we    = 1'b0;
		case (cmd.step)
			ost_pkg::S_APPEND: begin
				ol_waddr = count_q[ost_pkg::SLOT_W-1:0];
				ol_we    = (op_q != ost_pkg::OP_INSERT);
			end
			ost_pkg::S_INS_RD: begin
				ol_raddr = i_m1[ost_pkg::SLOT_W-1:0];
				ol_we    = sts.ins_done;
			end
			ost_pkg::S_INS_WR: begin
				ol_waddr = i_q[ost_pkg::SLOT_W-1:0];
				ol_wdata = ol_rd_q;
				ol_we    = 1'b1;
			end
			ost_pkg::S_RM_RD, ost_pkg::S_GET_RD, ost_pkg::S_SW_A: ol_raddr = p_q;
			ost_pkg::S_RM_WR: begin
				ol_waddr = i_m1[ost_pkg::SLOT_W-1:0];
				ol_wdata = ol_rd_q;
				ol_we    = 1'b1;
			end
			ost_pkg::S_SW_B: ol_raddr = ib_q;
			ost_pkg::S_SW_WA: begin
				ol_wdata = ol_rd_q;
				ol_we    = 1'b1;
			end
			ost_pkg::S_SW_WB: begin
				ol_waddr = ib_q;
				ol_wdata = t_q;
				ol_we    = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ol_we)
			ol_mem[ol_waddr] <= ol_wdata;
		ol_rd_q <= ol_mem[ol_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.step == ost_pkg::S_APPEND && op_q != ost_pkg::OP_RESERVE)
			es_mem[s_q] <= val_q;
		es_rd_q <= es_mem[ol_rd_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			holes_q <= '0;
			used_q  <= '0;
		end else begin
			case (cmd.step)
				ost_pkg::S_APPEND: begin
					used_q[s_q] <= 1'b1;
					count_q     <= count_q + 1'b1;
					if (holes_q != '0)
						holes_q <= holes_q - 1'b1;
				end
				ost_pkg::S_RM_SLOT: used_q[ol_rd_q] <= 1'b0;
				ost_pkg::S_RM_RDI: begin
					if (sts.loop_end) begin
						count_q <= count_q - 1'b1;
						holes_q <= holes_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q         <= opcode;
			ia_q         <= index_a;
			ib_q         <= index_b;
			val_q        <= element_value;
			nb_q         <= compare_bytes;
			res_status_q <= ost_pkg::ST_OK;
			res_pos_q    <= '0;
			res_slot_q   <= '0;
			res_data_q   <= '0;
		end
		if (cmd.set_bad)
			res_status_q <= ost_pkg::ST_BAD;
		if (cmd.set_full)
			res_status_q <= ost_pkg::ST_FULL;
		case (cmd.step)
			ost_pkg::S_DECODE: begin
				i_q <= '0;
				s_q <= count_q[ost_pkg::SLOT_W-1:0];
				p_q <= ia_q[ost_pkg::SLOT_W-1:0];
			end
			ost_pkg::S_SCAN: begin
				if (sts.slot_free)
					s_q <= i_q[ost_pkg::SLOT_W-1:0];
				else
					i_q <= i_q + 1'b1;
			end
			ost_pkg::S_APPEND: begin
				res_slot_q <= s_q;
				if (op_q == ost_pkg::OP_INSERT) begin
					p_q       <= ins_pos;
					i_q       <= count_q;
					res_pos_q <= ins_pos;
				end else begin
					res_pos_q <= count_q[ost_pkg::SLOT_W-1:0];
				end
			end
			ost_pkg::S_INS_WR: i_q <= i_m1;
			ost_pkg::S_RM_SLOT: i_q <= {1'b0, p_q} + 1'b1;
			ost_pkg::S_RM_RDI: begin
				if (sts.loop_end)
					res_pos_q <= p_q;
			end
			ost_pkg::S_RM_WR: i_q <= i_q + 1'b1;
			ost_pkg::S_GET_ES: res_slot_q <= ol_rd_q;
			ost_pkg::S_GET_DATA: begin
				res_data_q <= es_rd_q;
				res_pos_q  <= p_q;
			end
			ost_pkg::S_SW_B: t_q <= ol_rd_q;
			ost_pkg::S_SR_CMP: begin
				if (sts.match) begin
					res_pos_q <= i_q[ost_pkg::SLOT_W-1:0];
					p_q       <= i_q[ost_pkg::SLOT_W-1:0];
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
			default: ;
		endcase
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_pos_q    <= res_pos_q;
			out_slot_q   <= res_slot_q;
			out_data_q   <= res_data_q;
			out_count_q  <= count_q;
		end
	end

	assign status      = out_status_q;
	assign position    = out_pos_q;
	assign slot        = out_slot_q;
	assign read_data   = out_data_q;
	assign entry_count = out_count_q;

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ost_pkg::CNT_W'(ost_pkg::CAPACITY))
		else $error("entry count above capacity");

	a_high_water: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, count_q} + {1'b0, holes_q}) <= 8'(ost_pkg::CAPACITY))
		else $error("entries plus holes exceed capacity");

	a_slot_unused: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step == ost_pkg::S_APPEND |-> !used_q[s_q])
		else $error("new entry given a slot already in use");

endmodule

// ----- rtl/ost_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ost_ctrl
// Sequencer: decodes the opcode, steps the datapath through its walks and
// hands the result word to the output register.
// ----------------------------------------------------------------------------
module ost_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  ost_pkg::sts_t sts,
	output ost_pkg::cmd_t cmd
);

	logic [ost_pkg::STEP_W-1:0] state_q;
	logic [ost_pkg::STEP_W-1:0] state_d;
	logic                       out_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd.step     = state_q;
		cmd.take     = 1'b0;
		cmd.set_bad  = 1'b0;
		cmd.set_full = 1'b0;
		cmd.out_load = 1'b0;
		case (state_q)
			ost_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = ost_pkg::S_DECODE;
				end
			end
			ost_pkg::S_DECODE: begin
				case (sts.op)
					ost_pkg::OP_PUSH, ost_pkg::OP_RESERVE, ost_pkg::OP_INSERT: begin
						if (sts.full) begin
							cmd.set_full = 1'b1;
							state_d      = ost_pkg::S_FIN;
						end else if (sts.holes_nz) begin
							state_d = ost_pkg::S_SCAN;
						end else begin
							state_d = ost_pkg::S_APPEND;
						end
					end
					ost_pkg::OP_REMOVE_AT, ost_pkg::OP_GET: begin
						if (sts.pos_bad) begin
							cmd.set_bad = 1'b1;
							state_d     = ost_pkg::S_FIN;
						end else if (sts.op == ost_pkg::OP_GET) begin
							state_d = ost_pkg::S_GET_RD;
						end else begin
							state_d = ost_pkg::S_RM_RD;
						end
					end
					ost_pkg::OP_SWAP: begin
						if (sts.swap_bad) begin
							cmd.set_bad = 1'b1;
							state_d     = ost_pkg::S_FIN;
						end else begin
							state_d = ost_pkg::S_SW_A;
						end
					end
					ost_pkg::OP_FIND: begin
						if (sts.nb_bad) begin
							cmd.set_bad = 1'b1;
							state_d     = ost_pkg::S_FIN;
						end else begin
							state_d = ost_pkg::S_SR_OL;
						end
					end
					default: state_d = ost_pkg::S_SR_OL;
				endcase
			end
			ost_pkg::S_SCAN: begin
				if (sts.slot_free)
					state_d = ost_pkg::S_APPEND;
			end
			ost_pkg::S_APPEND: begin
				state_d = (sts.op == ost_pkg::OP_INSERT) ? ost_pkg::S_INS_RD : ost_pkg::S_FIN;
			end
			ost_pkg::S_INS_RD: state_d = sts.ins_done ? ost_pkg::S_FIN : ost_pkg::S_INS_WR;
			ost_pkg::S_INS_WR: state_d = ost_pkg::S_INS_RD;
			ost_pkg::S_RM_RD:   state_d = ost_pkg::S_RM_SLOT;
			ost_pkg::S_RM_SLOT: state_d = ost_pkg::S_RM_RDI;
			ost_pkg::S_RM_RDI:  state_d = sts.loop_end ? ost_pkg::S_FIN : ost_pkg::S_RM_WR;
			ost_pkg::S_RM_WR:   state_d = ost_pkg::S_RM_RDI;
			ost_pkg::S_GET_RD:   state_d = ost_pkg::S_GET_ES;
			ost_pkg::S_GET_ES:   state_d = ost_pkg::S_GET_DATA;
			ost_pkg::S_GET_DATA: state_d = ost_pkg::S_FIN;
			ost_pkg::S_SW_A:  state_d = ost_pkg::S_SW_B;
			ost_pkg::S_SW_B:  state_d = ost_pkg::S_SW_WA;
			ost_pkg::S_SW_WA: state_d = ost_pkg::S_SW_WB;
			ost_pkg::S_SW_WB: state_d = ost_pkg::S_FIN;
			ost_pkg::S_SR_OL: begin
				if (sts.loop_end) begin
					cmd.set_bad = 1'b1;
					state_d     = ost_pkg::S_FIN;
				end else begin
					state_d = ost_pkg::S_SR_ES;
				end
			end
			ost_pkg::S_SR_ES: state_d = ost_pkg::S_SR_CMP;
			ost_pkg::S_SR_CMP: begin
				if (!sts.match)
					state_d = ost_pkg::S_SR_OL;
				else if (sts.op == ost_pkg::OP_FIND)
					state_d = ost_pkg::S_FIN;
				else
					state_d = ost_pkg::S_RM_RD;
			end
			ost_pkg::S_FIN: begin
				// wait for the output register to free up
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = ost_pkg::S_IDLE;
				end
			end
			default: state_d = ost_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ost_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != ost_pkg::S_IDLE);
	assign out_valid = out_valid_q;

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> state_q == ost_pkg::S_DECODE)
		else $error("accepted word not decoded");

	a_valid_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ost_pkg::S_FIN))
		else $error("result word raised outside finish step");

	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ost_pkg::S_FIN && out_valid_q && out_stall) |=>
		state_q == ost_pkg::S_FIN)
		else $error("result overwrote a stalled word");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ordered slot table: directed corner words, a
// full-table test, then random opcode mixes. Results are compared against a
// behavioural copy of the table; both handshakes are throttled at random.
// ----------------------------------------------------------------------------
module tb_top;

	typedef struct {
		logic [1:0]                 status;
		logic [ost_pkg::SLOT_W-1:0] position;
		logic [ost_pkg::SLOT_W-1:0] slot;
		logic [31:0]                read_data;
		logic [ost_pkg::CNT_W-1:0]  entry_count;
	} result_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [2:0] opcode = '0;
	logic signed [ost_pkg::IDX_W-1:0] index_a = '0;
	logic [ost_pkg::SLOT_W-1:0] index_b = '0;
	logic [ost_pkg::ELEMENT_BITS-1:0] element_value = '0;
	logic [ost_pkg::NB_W-1:0] compare_bytes = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [1:0] status;
	logic [ost_pkg::SLOT_W-1:0] position;
	logic [ost_pkg::SLOT_W-1:0] slot;
	logic [ost_pkg::ELEMENT_BITS-1:0] read_data;
	logic [ost_pkg::CNT_W-1:0] entry_count;

	ordered_slot_table_top DUT (.*);

	// table copy
	logic [ost_pkg::SLOT_W-1:0] tbl_order [ost_pkg::CAPACITY];
	logic [31:0]                tbl_data  [ost_pkg::CAPACITY];
	bit                         tbl_written [ost_pkg::CAPACITY];
	int                         tbl_count = 0;
	int                         tbl_holes = 0;

	result_t pending_results[$];
	int      errors = 0;
	int      burst_left = 0;
	int      stall_mode = 0;
	int      idle_cycles = 0;

	initial forever #1 clk = ~clk;

	function automatic int lowest_free_slot();
		for (int c = 0; c <= tbl_count && c < ost_pkg::CAPACITY; c++) begin
			bit used;
			used = 0;
			for (int k = 0; k < tbl_count; k++)
				if (int'(tbl_order[k]) == c) used = 1;
			if (!used) return c;
		end
		return tbl_count < ost_pkg::CAPACITY ? tbl_count : 0;
	endfunction

	function automatic int next_slot();
		return tbl_holes > 0 ? lowest_free_slot() : tbl_count;
	endfunction

	function automatic int search_value(logic [31:0] v, int nbytes);
		logic [31:0] m;
		m = (nbytes >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * nbytes)) - 32'd1);
		for (int i = 0; i < tbl_count; i++)
			if (((tbl_data[tbl_order[i]] ^ v) & m) == 32'd0) return i;
		return -1;
	endfunction

	function automatic bit append_entry(bit wr, logic [31:0] v, output int s);
		s = 0;
		if (tbl_count >= ost_pkg::CAPACITY) return 0;
		s = next_slot();
		if (tbl_holes > 0) tbl_holes--;
		if (wr) begin
			tbl_data[s] = v;
			tbl_written[s] = 1;
		end
		tbl_order[tbl_count] = ost_pkg::SLOT_W'(s);
		tbl_count++;
		return 1;
	endfunction

	function automatic void remove_entry(int p);
		for (int i = p + 1; i < tbl_count; i++) tbl_order[i-1] = tbl_order[i];
		tbl_count--;
		tbl_holes++;
	endfunction

	// advances the table copy by one word and returns the expected result
	function automatic result_t table_step(logic [2:0] op, logic signed [7:0] ia8,
			logic [5:0] ib, logic [31:0] v, logic [2:0] nb);
		result_t r;
		int ia, s, f, p;
		logic [ost_pkg::SLOT_W-1:0] t;
		r = '{ost_pkg::ST_OK, '0, '0, '0, '0};
		ia = int'(ia8);
		case (op)
			ost_pkg::OP_PUSH, ost_pkg::OP_RESERVE: begin
				if (append_entry(op == ost_pkg::OP_PUSH, v, s)) begin
					r.position = ost_pkg::SLOT_W'(tbl_count - 1);
					r.slot = ost_pkg::SLOT_W'(s);
				end else r.status = ost_pkg::ST_FULL;
			end
			ost_pkg::OP_INSERT: begin
				p = ia < 0 ? 0 : (ia > tbl_count ? tbl_count : ia);
				if (!append_entry(1, v, s)) r.status = ost_pkg::ST_FULL;
				else begin
					for (int i = tbl_count - 1; i > p; i--) tbl_order[i] = tbl_order[i-1];
					tbl_order[p] = ost_pkg::SLOT_W'(s);
					r.position = ost_pkg::SLOT_W'(p);
					r.slot = ost_pkg::SLOT_W'(s);
				end
			end
			ost_pkg::OP_REMOVE_AT: begin
				if (ia < 0 || ia >= tbl_count) r.status = ost_pkg::ST_BAD;
				else begin
					remove_entry(ia);
					r.position = ost_pkg::SLOT_W'(ia);
				end
			end
			ost_pkg::OP_REMOVE_VALUE: begin
				f = search_value(v, 4);
				if (f < 0) r.status = ost_pkg::ST_BAD;
				else begin
					remove_entry(f);
					r.position = ost_pkg::SLOT_W'(f);
				end
			end
			ost_pkg::OP_SWAP: begin
				if (ia < 0 || ia >= tbl_count || int'(ib) >= tbl_count)
					r.status = ost_pkg::ST_BAD;
				else begin
					t = tbl_order[ia];
					tbl_order[ia] = tbl_order[ib];
					tbl_order[ib] = t;
				end
			end
			ost_pkg::OP_GET: begin
				if (ia < 0 || ia >= tbl_count) r.status = ost_pkg::ST_BAD;
				else begin
					r.position = ost_pkg::SLOT_W'(ia);
					r.slot = tbl_order[ia];
					r.read_data = tbl_data[tbl_order[ia]];
				end
			end
			default: begin
				f = (int'(nb) > ost_pkg::BYTES) ? -1 : search_value(v, int'(nb));
				if (f < 0) r.status = ost_pkg::ST_BAD;
				else r.position = ost_pkg::SLOT_W'(f);
			end
		endcase
		r.entry_count = ost_pkg::CNT_W'(tbl_count);
		return r;
	endfunction

	// one word through the input handshake; called on a rising edge
	task automatic send_word(logic [2:0] op, logic signed [7:0] ia, logic [5:0] ib,
			logic [31:0] v, logic [2:0] nb);
		int gap;
		// a reserve into a never-written slot would leave data undefined
		if (op == ost_pkg::OP_RESERVE && tbl_count < ost_pkg::CAPACITY &&
				!tbl_written[next_slot()])
			op = ost_pkg::OP_PUSH;
		in_valid <= 1;
		opcode <= op;
		index_a <= ia;
		index_b <= ib;
		element_value <= v;
		compare_bytes <= nb;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(table_step(op, ia, ib, v, nb));
		if (burst_left > 0) burst_left--;
		else begin
			burst_left = $urandom_range(0, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t unexpected result word: expected none actual status %0d",
					$time, status);
			end else begin
				e = pending_results.pop_front();
				cmp_field("status", 32'(e.status), 32'(status));
				cmp_field("position", 32'(e.position), 32'(position));
				cmp_field("slot", 32'(e.slot), 32'(slot));
				cmp_field("read_data", e.read_data, read_data);
				cmp_field("entry_count", 32'(e.entry_count), 32'(entry_count));
			end
		end
	end

	// receiver throttle: free-flowing, light and heavy stall stretches
	always @(posedge clk) begin
		if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
		case (stall_mode)
			0: out_stall <= 0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= 20000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic logic [31:0] rand_element();
		case ($urandom_range(0, 4))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 7);
			default: return $urandom;
		endcase
	endfunction

	// search key: usually a live value with random bytes above the compared ones
	function automatic logic [31:0] rand_key(int nbytes);
		logic [31:0] v, m;
		if (tbl_count == 0 || $urandom_range(0, 3) == 0) return rand_element();
		v = tbl_data[tbl_order[$urandom_range(0, tbl_count - 1)]];
		m = (nbytes >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * nbytes)) - 32'd1);
		return (v & m) | ($urandom & ~m);
	endfunction

	function automatic logic signed [7:0] rand_pos();
		if (tbl_count > 0 && $urandom_range(0, 4) != 0)
			return 8'($urandom_range(0, tbl_count - 1));
		return 8'($signed($urandom_range(0, 128)) - 64);
	endfunction

	task automatic test_directed();
		send_word(ost_pkg::OP_FIND, 0, 0, 0, 0);
		send_word(ost_pkg::OP_GET, 0, 0, 0, 0);
		send_word(ost_pkg::OP_PUSH, 0, 0, 32'h0, 0);
		send_word(ost_pkg::OP_PUSH, 0, 0, 32'hFFFF_FFFF, 0);
		send_word(ost_pkg::OP_INSERT, -64, 0, 32'h1234_5678, 0);
		send_word(ost_pkg::OP_INSERT, 64, 0, 32'hA5A5_5A5A, 0);
		send_word(ost_pkg::OP_GET, -64, 0, 0, 0);
		send_word(ost_pkg::OP_GET, 64, 0, 0, 0);
		send_word(ost_pkg::OP_GET, 3, 0, 0, 0);
		send_word(ost_pkg::OP_SWAP, 1, 1, 0, 0);
		send_word(ost_pkg::OP_SWAP, 0, 63, 0, 0);
		send_word(ost_pkg::OP_SWAP, 0, 3, 0, 0);
		send_word(ost_pkg::OP_FIND, 0, 0, 32'hDEAD_BEEF, 0);
		send_word(ost_pkg::OP_FIND, 0, 0, 32'h0000_0078, 1);
		send_word(ost_pkg::OP_FIND, 0, 0, 32'hFFFF_FFFF, 4);
		send_word(ost_pkg::OP_FIND, 0, 0, 32'hFFFF_FFFF, 5);
		send_word(ost_pkg::OP_FIND, 0, 0, 32'hFFFF_FFFF, 7);
		send_word(ost_pkg::OP_REMOVE_VALUE, 0, 0, 32'h0000_5678, 0);
		send_word(ost_pkg::OP_REMOVE_VALUE, 0, 0, 32'h1234_5678, 0);
		send_word(ost_pkg::OP_REMOVE_AT, -1, 0, 0, 0);
		send_word(ost_pkg::OP_REMOVE_AT, 0, 0, 0, 0);
		send_word(ost_pkg::OP_RESERVE, 0, 0, 32'h5555_5555, 0);
		send_word(ost_pkg::OP_GET, 2, 0, 0, 0);
		drain();
	endtask

	task automatic test_full_table();
		while (tbl_count < ost_pkg::CAPACITY) send_word(ost_pkg::OP_PUSH, 0, 0, $urandom, 0);
		send_word(ost_pkg::OP_PUSH, 0, 0, 32'h1, 0);
		send_word(ost_pkg::OP_RESERVE, 0, 0, 0, 0);
		send_word(ost_pkg::OP_INSERT, 5, 0, 32'h2, 0);
		send_word(ost_pkg::OP_GET, 63, 63, 0, 0);
		send_word(ost_pkg::OP_SWAP, 0, 63, 0, 0);
		drain();
		// punch holes, then refill through them with reserve and insert
		repeat (10)
			send_word(ost_pkg::OP_REMOVE_AT, 8'($urandom_range(0, tbl_count - 1)), 0, 0, 0);
		repeat (5) send_word(ost_pkg::OP_RESERVE, 0, 0, 0, 0);
		repeat (5) send_word(ost_pkg::OP_INSERT, 8'($urandom_range(0, 70)), 0, $urandom, 0);
		drain();
	endtask

	task automatic test_random_mix(int words, int grow_pct);
		logic [2:0] nb;
		for (int n = 0; n < words; n++) begin
			nb = 3'($urandom_range(0, 4));
			if ($urandom_range(0, 99) < grow_pct) begin
				case ($urandom_range(0, 2))
					0: send_word(ost_pkg::OP_PUSH, rand_pos(), 6'($urandom), rand_element(), nb);
					1: send_word(ost_pkg::OP_RESERVE, rand_pos(), 6'($urandom), $urandom, nb);
					default: send_word(ost_pkg::OP_INSERT,
						8'($signed($urandom_range(0, 128)) - 64),
						6'($urandom), rand_element(), nb);
				endcase
			end else begin
				case ($urandom_range(0, 4))
					0: send_word(ost_pkg::OP_REMOVE_AT, rand_pos(), 6'($urandom), $urandom, nb);
					1: send_word(ost_pkg::OP_REMOVE_VALUE, rand_pos(), 6'($urandom),
						rand_key(4), nb);
					2: send_word(ost_pkg::OP_SWAP, rand_pos(),
						6'(tbl_count > 0 ? $urandom_range(0, tbl_count) : $urandom),
						$urandom, nb);
					3: send_word(ost_pkg::OP_GET, rand_pos(), 6'($urandom), $urandom, nb);
					default: send_word(ost_pkg::OP_FIND, rand_pos(), 6'($urandom),
						rand_key(int'(nb)), nb);
				endcase
			end
		end
		drain();
	endtask

	initial begin
		for (int i = 0; i < ost_pkg::CAPACITY; i++) begin
			tbl_order[i] = '0;
			tbl_data[i] = '0;
			tbl_written[i] = 0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_full_table();
		test_random_mix(500, 50);
		test_random_mix(500, 85);
		test_random_mix(500, 45);
		test_random_mix(500, 10);
		repeat (300) @(posedge clk);
		if (errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/ost_pkg.sv
rtl/ost_dp.sv
rtl/ost_ctrl.sv
rtl/ordered_slot_table_top.sv
tb/tb_top.sv
